// ===== sv/pqe_pkg.sv =====
// Shared widths, codes, tables and stage payload types for the particle quad expander.
// No dependencies; every other file refers to it by scoped names.
package pqe_pkg;

    localparam int SLOT_W   = 14;
    localparam int POS_W    = 32;
    localparam int DIR_W    = 16;
    localparam int CHAN_W   = 17;
    localparam int COLOR_W  = 32;
    localparam int INDEX_W  = 16;
    localparam int OSLOT_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W   = POS_W + DIR_W;
    localparam int HALF_W   = PROD_W - 15;
    localparam int CPROD_W  = 2 * CHAN_W;
    localparam int CNT_W    = 4;

    localparam int MAX_PARTICLES = 16384;

    localparam logic [CHAN_W-1:0] TINT_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA = 8'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    localparam logic [CNT_W-1:0] NUM_CORNERS = 4'd4;
    localparam logic [CNT_W-1:0] LAST_CNT    = 4'd9;

    localparam logic [1:0] TRI_PATTERN [6] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2};
    localparam logic       CORNER_U    [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    localparam logic       CORNER_V    [4] = '{1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic [SLOT_W-1:0]        slotn;
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic signed [HALF_W-1:0] hsx;
        logic signed [HALF_W-1:0] hsy;
        logic [COLOR_W-1:0]       color;
    } quad_t;

    typedef struct packed {
        logic                     kind;
        logic [OSLOT_W-1:0]       slot;
        logic signed [POS_W-1:0]  vert_x;
        logic signed [POS_W-1:0]  vert_y;
        logic [COLOR_W-1:0]       packed_color;
        logic                     tex_u;
        logic                     tex_v;
        logic [INDEX_W-1:0]       index_value;
        logic                     last;
    } result_t;

endpackage

// ===== sv/pqe_particle_if.sv =====
// Particle input channel: valid/ready plus the particle fields.
// Depends on pqe_pkg for field widths.
interface pqe_particle_if;
    logic                              valid;
    logic                              ready;
    logic [pqe_pkg::SLOT_W-1:0]        particle_slot;
    logic signed [pqe_pkg::POS_W-1:0]  centre_x;
    logic signed [pqe_pkg::POS_W-1:0]  centre_y;
    logic signed [pqe_pkg::POS_W-1:0]  quad_size;
    logic signed [pqe_pkg::DIR_W-1:0]  dir_cos;
    logic signed [pqe_pkg::DIR_W-1:0]  dir_sin;
    logic [pqe_pkg::CHAN_W-1:0]        chan_red;
    logic [pqe_pkg::CHAN_W-1:0]        chan_green;
    logic [pqe_pkg::CHAN_W-1:0]        chan_blue;
    logic [pqe_pkg::CHAN_W-1:0]        chan_alpha;

    modport source (output valid, particle_slot, centre_x, centre_y, quad_size, dir_cos,
                    dir_sin, chan_red, chan_green, chan_blue, chan_alpha, input ready);
    modport sink   (input valid, particle_slot, centre_x, centre_y, quad_size, dir_cos,
                    dir_sin, chan_red, chan_green, chan_blue, chan_alpha, output ready);
endinterface

// ===== sv/pqe_result_if.sv =====
// Result output channel: valid/ready plus one vertex or index result.
// Depends on pqe_pkg for field widths.
interface pqe_result_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [pqe_pkg::OSLOT_W-1:0]       slot;
    logic signed [pqe_pkg::POS_W-1:0]  vert_x;
    logic signed [pqe_pkg::POS_W-1:0]  vert_y;
    logic [pqe_pkg::COLOR_W-1:0]       packed_color;
    logic                              tex_u;
    logic                              tex_v;
    logic [pqe_pkg::INDEX_W-1:0]       index_value;
    logic                              last;

    modport source (output valid, kind, slot, vert_x, vert_y, packed_color, tex_u, tex_v,
                    index_value, last, input ready);
    modport sink   (input valid, kind, slot, vert_x, vert_y, packed_color, tex_u, tex_v,
                    index_value, last, output ready);
endinterface

// ===== sv/pqe_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on pqe_pkg for widths.
interface pqe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pqe_pkg::CFG_IDX_W-1:0]   index;
    logic [pqe_pkg::CHAN_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/particle_quad_expander_core.sv =====
// Top level of the particle quad expander: front-end product stages and result sequencer.
// Depends on pqe_pkg, the three channel interfaces, pqe_calc and pqe_emit.
//
// Usage:
//   particle : one particle per transfer (slot, centre, size, direction, four channels).
//   result   : ten transfers per particle, four vertex results for corners 0..3, then
//              six index results 4*slot + {0,1,3,3,1,2}; last marks the tenth.
//   cfg      : tint register writes (index 0..3 red, green, blue, alpha); always ready,
//              unknown indices ignored. Write only while the block is idle.
// A particle's first result passes the input, product, sequencer and output registers in turn.
// Throughput: set by the result channel, moving one result per cycle out of the
//   output register while the receiver is ready. Up to three further particles are
//   held in the input, product and sequencer registers, so the next particle is taken
//   while the current one is still being sent.
// Reset: no particle in flight, all tints return to 1.0 (65536).
// Stall: when the receiver drops ready the output register holds its result and the
//   pipeline fills, then particle ready falls; nothing is lost or repeated.
module particle_quad_expander_core (
    input  logic           clk,
    input  logic           rst_n,
    pqe_particle_if.sink   particle,
    pqe_cfg_if.sink        cfg,
    pqe_result_if.source   result
);

    logic           quad_valid;
    logic           quad_ready;
    pqe_pkg::quad_t quad;

    pqe_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .particle   (particle),
        .cfg        (cfg),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad)
    );

    pqe_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .result     (result)
    );

endmodule

// ===== sv/pqe_calc.sv =====
// Front end: tint registers, input register and product register stage.
// Produces one quad_t per particle. Depends on pqe_pkg and the particle/cfg interfaces.
module pqe_calc (
    input  logic               clk,
    input  logic               rst_n,
    pqe_particle_if.sink       particle,
    pqe_cfg_if.sink            cfg,
    output logic               quad_valid,
    input  logic               quad_ready,
    output pqe_pkg::quad_t     quad
);

    logic [pqe_pkg::CHAN_W-1:0] tint_red_reg, tint_green_reg, tint_blue_reg, tint_alpha_reg;

    // stage 1: captured particle
    logic                               s1_valid_reg;
    logic [pqe_pkg::SLOT_W-1:0]         s1_slot_reg;
    logic signed [pqe_pkg::POS_W-1:0]   s1_cx_reg, s1_cy_reg, s1_size_reg;
    logic signed [pqe_pkg::DIR_W-1:0]   s1_cos_reg, s1_sin_reg;
    logic [pqe_pkg::CHAN_W-1:0]         s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;

    // stage 2: products
    logic                               s2_valid_reg;
    logic [pqe_pkg::SLOT_W-1:0]         s2_slot_reg;
    logic signed [pqe_pkg::POS_W-1:0]   s2_cx_reg, s2_cy_reg;
    logic signed [pqe_pkg::PROD_W-1:0]  s2_px_reg, s2_py_reg;
    logic signed [pqe_pkg::PROD_W-1:0]  px_next, py_next;
    logic [pqe_pkg::CPROD_W-1:0]        s2_pr_reg, s2_pg_reg, s2_pb_reg, s2_pa_reg;

    logic s1_ready, s2_ready, s1_load, s2_load;

    function automatic logic [7:0] color_byte(input logic [pqe_pkg::CPROD_W-1:0] p);
        logic [pqe_pkg::CPROD_W+8:0] q;
        logic [9:0]                  b;
        q = {p, 9'd0} - {9'd0, p};
        b = q[pqe_pkg::CPROD_W+8:33];
        color_byte = (b > 10'd255) ? 8'd255 : b[7:0];
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_red_reg   <= pqe_pkg::TINT_RESET;
            tint_green_reg <= pqe_pkg::TINT_RESET;
            tint_blue_reg  <= pqe_pkg::TINT_RESET;
            tint_alpha_reg <= pqe_pkg::TINT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pqe_pkg::REG_TINT_RED:   tint_red_reg   <= cfg.data;
                pqe_pkg::REG_TINT_GREEN: tint_green_reg <= cfg.data;
                pqe_pkg::REG_TINT_BLUE:  tint_blue_reg  <= cfg.data;
                pqe_pkg::REG_TINT_ALPHA: tint_alpha_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign s2_ready       = !s2_valid_reg || quad_ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    assign particle.ready = s1_ready;
    assign s1_load        = particle.valid && s1_ready;
    assign s2_load        = s1_valid_reg && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= particle.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_slot_reg <= pqe_pkg::SLOT_W'(32'(particle.particle_slot) % pqe_pkg::MAX_PARTICLES);
            s1_cx_reg   <= particle.centre_x;
            s1_cy_reg   <= particle.centre_y;
            s1_size_reg <= particle.quad_size;
            s1_cos_reg  <= particle.dir_cos;
            s1_sin_reg  <= particle.dir_sin;
            s1_r_reg    <= particle.chan_red;
            s1_g_reg    <= particle.chan_green;
            s1_b_reg    <= particle.chan_blue;
            s1_a_reg    <= particle.chan_alpha;
        end
    end

    assign px_next = pqe_pkg::PROD_W'(s1_size_reg) * pqe_pkg::PROD_W'(s1_cos_reg);
    assign py_next = pqe_pkg::PROD_W'(s1_size_reg) * pqe_pkg::PROD_W'(s1_sin_reg);

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_slot_reg <= s1_slot_reg;
            s2_cx_reg   <= s1_cx_reg;
            s2_cy_reg   <= s1_cy_reg;
            s2_px_reg   <= px_next;
            s2_py_reg   <= py_next;
            s2_pr_reg   <= pqe_pkg::CPROD_W'(tint_red_reg)   * pqe_pkg::CPROD_W'(s1_r_reg);
            s2_pg_reg   <= pqe_pkg::CPROD_W'(tint_green_reg) * pqe_pkg::CPROD_W'(s1_g_reg);
            s2_pb_reg   <= pqe_pkg::CPROD_W'(tint_blue_reg)  * pqe_pkg::CPROD_W'(s1_b_reg);
            s2_pa_reg   <= pqe_pkg::CPROD_W'(tint_alpha_reg) * pqe_pkg::CPROD_W'(s1_a_reg);
        end
    end

    // floor(p / 32768) is the top bits of the product
    assign quad_valid  = s2_valid_reg;
    assign quad.slotn  = s2_slot_reg;
    assign quad.cx     = s2_cx_reg;
    assign quad.cy     = s2_cy_reg;
    assign quad.hsx    = s2_px_reg[pqe_pkg::PROD_W-1:15];
    assign quad.hsy    = s2_py_reg[pqe_pkg::PROD_W-1:15];
    assign quad.color  = {color_byte(s2_pa_reg), color_byte(s2_pr_reg),
                          color_byte(s2_pg_reg), color_byte(s2_pb_reg)};

endmodule

// ===== sv/pqe_emit.sv =====
// Back end: holds one quad and sequences its ten results into the output register.
// Depends on pqe_pkg and the result interface.
module pqe_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quad_valid,
    output logic               quad_ready,
    input  pqe_pkg::quad_t     quad,
    pqe_result_if.source       result
);

    localparam int SUM_W = pqe_pkg::HALF_W + 2;

    logic                         busy_reg;
    logic [pqe_pkg::CNT_W-1:0]    cnt_reg;
    pqe_pkg::quad_t               quad_reg;
    logic                         out_valid_reg;
    pqe_pkg::result_t             res_reg;
    pqe_pkg::result_t             res_next;

    logic adv, load, done;
    logic [1:0]                   corner;
    logic [2:0]                   ipos;
    logic signed [SUM_W-1:0]      ta, tb, tya, tyb, sx, sy;

    function automatic logic signed [pqe_pkg::POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(32'sh7fffffff))
            sat32 = 32'sh7fffffff;
        else if (v < -SUM_W'(33'sh080000000))
            sat32 = 32'sh80000000;
        else
            sat32 = v[pqe_pkg::POS_W-1:0];
    endfunction

    assign adv        = busy_reg && (!out_valid_reg || result.ready);
    assign done       = adv && (cnt_reg == pqe_pkg::LAST_CNT);
    assign quad_ready = !busy_reg || done;
    assign load       = quad_valid && quad_ready;

    assign corner = cnt_reg[1:0];
    assign ipos   = 3'(cnt_reg - pqe_pkg::NUM_CORNERS);

    // x = cx -/+ hsx -/+ hsy, y = cy -/+ hsy -/+ hsx per corner
    always_comb
    begin
        ta  = SUM_W'(quad_reg.hsx);
        tb  = SUM_W'(quad_reg.hsy);
        tya = SUM_W'(quad_reg.hsx);
        tyb = SUM_W'(quad_reg.hsy);
        if (corner == 2'd0 || corner == 2'd3)
            ta = -ta;
        if (corner == 2'd0 || corner == 2'd1)
            tb = -tb;
        if (corner == 2'd2 || corner == 2'd3)
            tya = -tya;
        if (corner == 2'd0 || corner == 2'd3)
            tyb = -tyb;
        sx = SUM_W'(quad_reg.cx) + ta + tb;
        sy = SUM_W'(quad_reg.cy) + tya + tyb;
    end

    always_comb
    begin
        res_next = '0;
        if (cnt_reg < pqe_pkg::NUM_CORNERS)
        begin
            res_next.kind         = pqe_pkg::KIND_VERTEX;
            res_next.slot         = {1'b0, corner};
            res_next.vert_x       = sat32(sx);
            res_next.vert_y       = sat32(sy);
            res_next.packed_color = quad_reg.color;
            res_next.tex_u        = pqe_pkg::CORNER_U[corner];
            res_next.tex_v        = pqe_pkg::CORNER_V[corner];
        end
        else
        begin
            res_next.kind        = pqe_pkg::KIND_INDEX;
            res_next.slot        = ipos;
            res_next.index_value = {quad_reg.slotn, 2'b00}
                                 + {14'd0, pqe_pkg::TRI_PATTERN[ipos]};
            res_next.last        = (cnt_reg == pqe_pkg::LAST_CNT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (done)
                busy_reg <= 1'b0;
            else if (adv)
                cnt_reg <= cnt_reg + 4'd1;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            quad_reg <= quad;
        if (adv)
            res_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = res_reg.kind;
    assign result.slot         = res_reg.slot;
    assign result.vert_x       = res_reg.vert_x;
    assign result.vert_y       = res_reg.vert_y;
    assign result.packed_color = res_reg.packed_color;
    assign result.tex_u        = res_reg.tex_u;
    assign result.tex_v        = res_reg.tex_v;
    assign result.index_value  = res_reg.index_value;
    assign result.last         = res_reg.last;

endmodule

// ===== tb/particle_quad_expander_core_tb.sv =====
// Self-checking testbench for particle_quad_expander_core: random and directed particles,
// tint register phases, a scoreboard predicting the ten results of every particle.
// Depends on pqe_pkg, the particle, cfg and result channel interfaces, and the core.
module particle_quad_expander_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 38;
    localparam int HOLD_CYCLES = 300;
    localparam logic [pqe_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = 8'd4;
    localparam logic [pqe_pkg::CFG_IDX_W-1:0] TINT_REGS [4] =
        '{pqe_pkg::REG_TINT_RED, pqe_pkg::REG_TINT_GREEN,
          pqe_pkg::REG_TINT_BLUE, pqe_pkg::REG_TINT_ALPHA};

    typedef logic [pqe_pkg::CHAN_W-1:0] chan_t;

    typedef struct {
        logic [pqe_pkg::SLOT_W-1:0]       particle_slot;
        logic signed [pqe_pkg::POS_W-1:0] centre_x;
        logic signed [pqe_pkg::POS_W-1:0] centre_y;
        logic signed [pqe_pkg::POS_W-1:0] quad_size;
        logic signed [pqe_pkg::DIR_W-1:0] dir_cos;
        logic signed [pqe_pkg::DIR_W-1:0] dir_sin;
        chan_t                            chan_red;
        chan_t                            chan_green;
        chan_t                            chan_blue;
        chan_t                            chan_alpha;
    } particle_t;

    class quad_scoreboard;
        chan_t tint_red;
        chan_t tint_green;
        chan_t tint_blue;
        chan_t tint_alpha;
        pqe_pkg::result_t pending[$];
        int errors;

        function new();
            tint_red   = pqe_pkg::TINT_RESET;
            tint_green = pqe_pkg::TINT_RESET;
            tint_blue  = pqe_pkg::TINT_RESET;
            tint_alpha = pqe_pkg::TINT_RESET;
            errors     = 0;
        endfunction

        function void write_reg(logic [pqe_pkg::CFG_IDX_W-1:0] idx, chan_t val);
            case (idx)
                pqe_pkg::REG_TINT_RED:   tint_red   = val;
                pqe_pkg::REG_TINT_GREEN: tint_green = val;
                pqe_pkg::REG_TINT_BLUE:  tint_blue  = val;
                pqe_pkg::REG_TINT_ALPHA: tint_alpha = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] colour_byte(chan_t tint, chan_t chan);
            longint unsigned prod;
            prod = longint'(tint) * longint'(chan) * 511;
            prod = prod >> 33;
            return (prod > 255) ? 8'hFF : prod[7:0];
        endfunction

        function logic [pqe_pkg::POS_W-1:0] sat_pos(longint v);
            if (v > longint'(32'sh7FFF_FFFF))
                return 32'h7FFF_FFFF;
            if (v < -longint'(64'h8000_0000))
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void note_particle(particle_t p);
            longint half_x;
            longint half_y;
            longint su;
            longint sv;
            int slotn;
            logic [pqe_pkg::COLOR_W-1:0] argb;
            pqe_pkg::result_t r;
            // floor division by 32768: the half-size folded into the shift
            half_x = (longint'(p.quad_size) * longint'(p.dir_cos)) >>> 15;
            half_y = (longint'(p.quad_size) * longint'(p.dir_sin)) >>> 15;
            argb = {colour_byte(tint_alpha, p.chan_alpha), colour_byte(tint_red, p.chan_red),
                    colour_byte(tint_green, p.chan_green), colour_byte(tint_blue, p.chan_blue)};
            for (int k = 0; k < 4; k++)
            begin
                su = (k == 0 || k == 3) ? -1 : 1;
                sv = (k < 2) ? 1 : -1;
                r = '0;
                r.kind = pqe_pkg::KIND_VERTEX;
                r.slot = 3'(k);
                r.vert_x = sat_pos(longint'(p.centre_x) + su * half_x - sv * half_y);
                r.vert_y = sat_pos(longint'(p.centre_y) + su * half_y + sv * half_x);
                r.packed_color = argb;
                r.tex_u = pqe_pkg::CORNER_U[k];
                r.tex_v = pqe_pkg::CORNER_V[k];
                pending.push_back(r);
            end
            slotn = int'(p.particle_slot) % pqe_pkg::MAX_PARTICLES;
            for (int k = 0; k < 6; k++)
            begin
                r = '0;
                r.kind = pqe_pkg::KIND_INDEX;
                r.slot = 3'(k);
                r.index_value = 16'(slotn * 4 + int'(pqe_pkg::TRI_PATTERN[k]));
                r.last = (k == 5);
                pending.push_back(r);
            end
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(pqe_pkg::result_t got);
            pqe_pkg::result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0d slot %0d",
                       got.kind, got.slot);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            cmp("kind", 32'(exp_r.kind), 32'(got.kind));
            cmp("slot", 32'(exp_r.slot), 32'(got.slot));
            cmp("vert_x", exp_r.vert_x, got.vert_x);
            cmp("vert_y", exp_r.vert_y, got.vert_y);
            cmp("packed_color", exp_r.packed_color, got.packed_color);
            cmp("tex_u", 32'(exp_r.tex_u), 32'(got.tex_u));
            cmp("tex_v", 32'(exp_r.tex_v), 32'(got.tex_v));
            cmp("index_value", 32'(exp_r.index_value), 32'(got.index_value));
            cmp("last", 32'(exp_r.last), 32'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_output;
    bit   gaps_enabled = 1'b1;
    int   particles_sent = 0;
    quad_scoreboard sb = new();

    pqe_particle_if particle_ch();
    pqe_cfg_if      cfg_ch();
    pqe_result_if   result_ch();

    particle_quad_expander_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle_ch),
        .cfg      (cfg_ch),
        .result   (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("particle_quad_expander_core regression: fail");
        $finish;
    end

    function automatic chan_t rand_chan();
        if ($urandom_range(0, 5) == 0)
            return chan_t'($urandom);
        return chan_t'($urandom_range(0, 65536));
    endfunction

    function automatic logic signed [15:0] rand_dir();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.particle_slot = 14'($urandom);
        p.centre_x   = $signed($urandom) >>> $urandom_range(0, 24);
        p.centre_y   = $signed($urandom) >>> $urandom_range(0, 24);
        p.quad_size  = $signed($urandom) >>> $urandom_range(0, 24);
        p.dir_cos    = rand_dir();
        p.dir_sin    = rand_dir();
        p.chan_red   = rand_chan();
        p.chan_green = rand_chan();
        p.chan_blue  = rand_chan();
        p.chan_alpha = rand_chan();
        return p;
    endfunction

    function automatic particle_t particle_of(logic [13:0] slot, logic [31:0] cx,
                                              logic [31:0] cy, logic [31:0] size,
                                              logic [15:0] dc, logic [15:0] ds,
                                              chan_t r, chan_t g, chan_t b, chan_t a);
        particle_t p;
        p.particle_slot = slot;
        p.centre_x   = cx;
        p.centre_y   = cy;
        p.quad_size  = size;
        p.dir_cos    = dc;
        p.dir_sin    = ds;
        p.chan_red   = r;
        p.chan_green = g;
        p.chan_blue  = b;
        p.chan_alpha = a;
        return p;
    endfunction

    task automatic send_particle(particle_t p);
        if (gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            particle_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        particle_ch.valid         <= 1'b1;
        particle_ch.particle_slot <= p.particle_slot;
        particle_ch.centre_x      <= p.centre_x;
        particle_ch.centre_y      <= p.centre_y;
        particle_ch.quad_size     <= p.quad_size;
        particle_ch.dir_cos       <= p.dir_cos;
        particle_ch.dir_sin       <= p.dir_sin;
        particle_ch.chan_red      <= p.chan_red;
        particle_ch.chan_green    <= p.chan_green;
        particle_ch.chan_blue     <= p.chan_blue;
        particle_ch.chan_alpha    <= p.chan_alpha;
        do @(posedge clk); while (!particle_ch.ready);
        sb.note_particle(p);
        particles_sent++;
    endtask

    task automatic cfg_write(logic [pqe_pkg::CFG_IDX_W-1:0] idx, chan_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
    endtask

    task automatic write_tints(chan_t r, chan_t g, chan_t b, chan_t a);
        chan_t vals [4];
        vals = '{r, g, b, a};
        for (int i = 0; i < 4; i++)
            cfg_write(TINT_REGS[i], vals[i]);
        // unused index must leave the tints alone
        cfg_write(8'($urandom_range(FIRST_UNUSED_REG, 255)), rand_chan());
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        particle_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // receiver: random stalls plus one long hold to back the pipeline up
    initial
    begin : result_sink
        int stall;
        pqe_pkg::result_t got;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.kind         = result_ch.kind;
                got.slot         = result_ch.slot;
                got.vert_x       = result_ch.vert_x;
                got.vert_y       = result_ch.vert_y;
                got.packed_color = result_ch.packed_color;
                got.tex_u        = result_ch.tex_u;
                got.tex_v        = result_ch.tex_v;
                got.index_value  = result_ch.index_value;
                got.last         = result_ch.last;
                sb.check_result(got);
            end
            if (stall > 0)
                stall--;
            else if (gaps_enabled && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 14);
            result_ch.ready <= !hold_output && stall == 0;
        end
    end

    initial
    begin : output_hold
        hold_output <= 1'b0;
        wait (particles_sent >= 60);
        @(posedge clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
    end

    initial
    begin : stimulus
        rst_n                     <= 1'b0;
        particle_ch.valid         <= 1'b0;
        particle_ch.particle_slot <= '0;
        particle_ch.centre_x      <= '0;
        particle_ch.centre_y      <= '0;
        particle_ch.quad_size     <= '0;
        particle_ch.dir_cos       <= '0;
        particle_ch.dir_sin       <= '0;
        particle_ch.chan_red      <= '0;
        particle_ch.chan_green    <= '0;
        particle_ch.chan_blue     <= '0;
        particle_ch.chan_alpha    <= '0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.index              <= '0;
        cfg_ch.data               <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tints; extremes of every field
        send_particle(particle_of(14'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0,
                                  17'd0, 17'd0, 17'd0, 17'd0));
        send_particle(particle_of(14'h3FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  16'sd16384, 16'sd16384, 17'd65536, 17'd65536,
                                  17'd65536, 17'd65536));
        send_particle(particle_of(14'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  -16'sd16384, 16'sd16384, 17'd0, 17'd65536,
                                  17'd0, 17'd65536));
        send_particle(particle_of(14'd1, 32'd0, 32'd0, 32'h8000_0000, 16'h8000, 16'h8000,
                                  17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        send_particle(particle_of(14'h2AAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                  16'h7FFF, 16'h8000, 17'd65535, 17'd65537,
                                  17'd32768, 17'd1));
        send_particle(particle_of(14'h1555, 32'h0001_0000, 32'hFFFF_0000, 32'd1,
                                  16'sd1, -16'sd1, 17'd1, 17'd2, 17'd3, 17'd4));
        send_particle(particle_of(14'd100, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'sd16384, 16'sd0,
                                  17'd256, 17'd257, 17'd255, 17'd128));
        send_particle(particle_of(14'd4095, 32'h0010_0000, 32'h0020_0000, 32'h0001_0000,
                                  16'sd16384, 16'sd0, 17'd65536, 17'd0, 17'd0, 17'd0));
        send_particle(particle_of(14'd8192, 32'hFFF0_0000, 32'h0005_8000, 32'h0020_0000,
                                  16'sd11585, 16'sd11585, 17'd0, 17'd65536, 17'd0, 17'd0));
        send_particle(particle_of(14'd16382, 32'h7FFF_0000, 32'h8001_0000, 32'h0400_0000,
                                  16'sd0, -16'sd16384, 17'd0, 17'd0, 17'd65536, 17'd0));
        send_particle(particle_of(14'd3, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_8000,
                                  -16'sd11585, 16'sd11585, 17'd65537, 17'd98304,
                                  17'd131070, 17'd65536));
        send_particle(particle_of(14'd9999, 32'h1234_5678, 32'hEDCB_A987, 32'hFFF0_0000,
                                  16'sd5000, -16'sd15000, 17'd12345, 17'd54321,
                                  17'd40000, 17'd20000));
        repeat (6) send_particle(rand_particle());

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph)
                0: write_tints(17'd0, 17'd0, 17'd0, 17'd0);
                1: write_tints(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
                2: write_tints(17'd65536, 17'd0, 17'h1FFFF, 17'd32768);
                5: write_tints(pqe_pkg::TINT_RESET, pqe_pkg::TINT_RESET,
                               pqe_pkg::TINT_RESET, pqe_pkg::TINT_RESET);
                default: write_tints(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            endcase
            if (ph == 5)
                gaps_enabled = 1'b0;
            repeat (PHASE_ITEMS) send_particle(rand_particle());
        end
        drain_results();
        repeat (12) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("particle_quad_expander_core regression: pass");
        else
            $display("particle_quad_expander_core regression: fail");
        $finish;
    end

endmodule
